// ===== design/pbh_pkg.sv =====
// Shared types, sizes, register codes and helpers for the particle box histogram.
package pbh_pkg;

    // Grid and counter sizing.
    localparam int MAX_BOXES_X = 16;
    localparam int MAX_BOXES_Y = 16;
    localparam int MAX_BOXES_Z = 16;
    localparam int COUNT_BITS  = 32;

    localparam int IDX_X_W = $clog2(MAX_BOXES_X);
    localparam int IDX_Y_W = $clog2(MAX_BOXES_Y);
    localparam int IDX_Z_W = $clog2(MAX_BOXES_Z);
    localparam int IDX_XY_W = (IDX_X_W > IDX_Y_W) ? IDX_X_W : IDX_Y_W;
    localparam int IDX_W   = (IDX_XY_W > IDX_Z_W) ? IDX_XY_W : IDX_Z_W;

    localparam int DEPTH   = MAX_BOXES_X * MAX_BOXES_Y * MAX_BOXES_Z;
    localparam int ADDR_W  = $clog2(DEPTH);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // Field widths fixed by the interface.
    localparam int POS_W   = 32;
    localparam int SEL_W   = 4;
    localparam int BOX_W   = 4;
    localparam int CONC_W  = 64;
    localparam int MUL_W   = 32;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int FRAC_SH = 40;
    localparam int IDXH_W  = PROD_W - FRAC_SH;
    localparam int CMP_W   = IDXH_W + 1;
    localparam int CNT_W   = 5;
    localparam int DIMS_W  = 18;
    localparam int FLAT_LSB = 15;

    // Configuration port.
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_BOX_X = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_BOX_Y = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_BOX_Z = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_DIMS = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_CONC_SCL  = 4'd7;

    localparam logic [MUL_W-1:0]  RST_INV   = 32'h0100_0000;
    localparam logic [DIMS_W-1:0] RST_DIMS  = 18'h04210;
    localparam logic [MUL_W-1:0]  RST_SCALE = 32'h0001_0000;

    // Item kinds.
    localparam logic KIND_BIN  = 1'b0;
    localparam logic KIND_READ = 1'b1;

    // Operand selection of the shared multiplier; the axis codes double as axis numbers.
    typedef enum logic [2:0] {
        MSEL_X   = 3'd0,
        MSEL_Y   = 3'd1,
        MSEL_Z   = 3'd2,
        MSEL_CLO = 3'd3,
        MSEL_CHI = 3'd4
    } t_mul_sel;

    typedef struct packed {
        logic     load;
        logic     sub_en;
        logic     mul_en;
        logic     chk_en;
        t_mul_sel msel;
        logic     rd_en;
        logic     upd_wr;
        logic     sum_en;
        logic     out_load;
        logic     clr_wr;
    } t_dp_cmd;

    typedef struct packed {
        logic kind;
        logic go;
        logic sel_ok;
        logic all_ok;
        logic clr_last;
    } t_dp_sts;

    // Box count of one axis, limited to the grid size of that axis.
    function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] f,
                                                   input int unsigned m);
        logic [6:0] mm;
        mm = 7'(m);
        return (7'(f) > mm) ? mm[CNT_W-1:0] : f;
    endfunction

    // Flat store address of a box.
    function automatic logic [ADDR_W-1:0] box_addr(input logic [IDX_W-1:0] x,
                                                   input logic [IDX_W-1:0] y,
                                                   input logic [IDX_W-1:0] z);
        logic [ADDR_W-1:0] a;
        a = ADDR_W'(z) * ADDR_W'(MAX_BOXES_Y) + ADDR_W'(y);
        a = a * ADDR_W'(MAX_BOXES_X) + ADDR_W'(x);
        return a;
    endfunction

endpackage

// ===== design/pbh_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module pbh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== design/pbh_ctrl.sv =====
// Sequencing state machine of the particle box histogram.
module pbh_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    input  pbh_pkg::t_dp_sts i_sts,
    output pbh_pkg::t_dp_cmd o_cmd
);
    import pbh_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_SUB,
        S_MX, S_CX, S_MY, S_CY, S_MZ, S_CZ,
        S_RD, S_RDW, S_MLO, S_MHI, S_SUM, S_DONE
    } t_state;

    t_state  r_state, n_state;
    logic    r_out_valid, n_out_valid;
    t_dp_cmd cmd;
    logic    out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        cmd     = '0;
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_state  = S_SUB;
                end
            end
            S_SUB: begin
                cmd.sub_en = 1'b1;
                if (i_sts.kind == KIND_READ) begin
                    n_state = i_sts.sel_ok ? S_RD : S_DONE;
                end else begin
                    n_state = i_sts.go ? S_MX : S_DONE;
                end
            end
            S_MX: begin
                cmd.mul_en = 1'b1;
                cmd.msel   = MSEL_X;
                n_state    = S_CX;
            end
            S_CX: begin
                cmd.chk_en = 1'b1;
                cmd.msel   = MSEL_X;
                n_state    = S_MY;
            end
            S_MY: begin
                cmd.mul_en = 1'b1;
                cmd.msel   = MSEL_Y;
                n_state    = S_CY;
            end
            S_CY: begin
                cmd.chk_en = 1'b1;
                cmd.msel   = MSEL_Y;
                n_state    = S_MZ;
            end
            S_MZ: begin
                cmd.mul_en = 1'b1;
                cmd.msel   = MSEL_Z;
                n_state    = S_CZ;
            end
            S_CZ: begin
                cmd.chk_en = 1'b1;
                cmd.msel   = MSEL_Z;
                n_state    = i_sts.all_ok ? S_RD : S_DONE;
            end
            S_RD: begin
                cmd.rd_en = 1'b1;
                n_state   = S_RDW;
            end
            S_RDW: begin
                cmd.upd_wr = 1'b1;
                n_state    = (i_sts.kind == KIND_READ) ? S_MLO : S_DONE;
            end
            S_MLO: begin
                cmd.mul_en = 1'b1;
                cmd.msel   = MSEL_CLO;
                n_state    = S_MHI;
            end
            S_MHI: begin
                cmd.mul_en = 1'b1;
                cmd.msel   = MSEL_CHI;
                n_state    = S_SUM;
            end
            S_SUM: begin
                cmd.sum_en = 1'b1;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_out_valid = cmd.out_load ? 1'b1 : (r_out_valid && i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> r_state == S_SUB)
        else $error("accepted item did not start processing");

    a_taken_drops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_stall && r_state != S_DONE |=> !r_out_valid)
        else $error("taken result was presented again");

    a_no_result_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CLEAR |-> !r_out_valid)
        else $error("result presented during clearing pass");

endmodule

// ===== design/pbh_dp.sv =====
// Datapath of the particle box histogram: config registers, index math, counter store.
module pbh_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  pbh_pkg::t_dp_cmd                     i_cmd,
    output pbh_pkg::t_dp_sts                     o_sts,
    input  logic                                 i_cfg_we,
    input  logic [pbh_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [pbh_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                                 i_kind,
    input  logic signed [pbh_pkg::POS_W-1:0]     i_x_pos,
    input  logic signed [pbh_pkg::POS_W-1:0]     i_y_pos,
    input  logic signed [pbh_pkg::POS_W-1:0]     i_z_pos,
    input  logic                                 i_active,
    input  logic                                 i_released,
    input  logic [pbh_pkg::SEL_W-1:0]            i_sel_x,
    input  logic [pbh_pkg::SEL_W-1:0]            i_sel_y,
    input  logic [pbh_pkg::SEL_W-1:0]            i_sel_z,
    output logic                                 o_in_range,
    output logic [pbh_pkg::BOX_W-1:0]            o_box_x,
    output logic [pbh_pkg::BOX_W-1:0]            o_box_y,
    output logic [pbh_pkg::BOX_W-1:0]            o_box_z,
    output logic [pbh_pkg::CONC_W-1:0]           o_concentration
);
    import pbh_pkg::*;

    // Configuration.
    logic signed [POS_W-1:0] r_origin [3];
    logic [MUL_W-1:0]        r_inv [3];
    logic [DIMS_W-1:0]       r_dims;
    logic [MUL_W-1:0]        r_scale;

    // Item being processed.
    logic                    r_kind;
    logic                    r_go;
    logic signed [POS_W-1:0] r_pos [3];
    logic [SEL_W-1:0]        r_sel [3];

    // Working registers.
    logic [MUL_W-1:0]        r_mag [3];
    logic                    r_neg [3];
    logic [IDX_W-1:0]        r_idx [3];
    logic                    r_all_ok;
    logic [PROD_W-1:0]       r_prod;
    logic [PROD_W-1:0]       r_p0;
    logic [ADDR_W-1:0]       r_addr;
    logic [COUNT_BITS-1:0]   r_cnt;
    logic                    r_hit;
    logic [CONC_W-1:0]       r_conc;
    logic [ADDR_W-1:0]       r_clr_addr;

    // Result register.
    logic                    r_o_hit;
    logic [BOX_W-1:0]        r_o_box [3];
    logic [CONC_W-1:0]       r_o_conc;

    logic [CNT_W-1:0]        n_eff [3];
    logic                    sel_ok;
    logic [1:0]              ax;
    logic [MUL_W-1:0]        mul_a, mul_b;
    logic [PROD_W-1:0]       mul_p;
    logic [IDXH_W-1:0]       idx_hi;
    logic                    ax_neg, ax_flat, e_valid, axis_ok;
    logic [IDXH_W-1:0]       e;
    logic [PROD_W-1:0]       cnt_ext;
    logic [MUL_W:0]          conc_mid;
    logic                    conc_sat;
    logic [ADDR_W-1:0]       n_addr;
    logic [COUNT_BITS-1:0]   rd_data, upd_data, wr_data;
    logic [ADDR_W-1:0]       wr_addr;
    logic                    wr_en;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_origin[k] <= '0;
                r_inv[k]    <= RST_INV;
            end
            r_dims  <= RST_DIMS;
            r_scale <= RST_SCALE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ORIGIN_X:  r_origin[0] <= i_cfg_data;
                CFG_ORIGIN_Y:  r_origin[1] <= i_cfg_data;
                CFG_ORIGIN_Z:  r_origin[2] <= i_cfg_data;
                CFG_INV_BOX_X: r_inv[0]    <= i_cfg_data;
                CFG_INV_BOX_Y: r_inv[1]    <= i_cfg_data;
                CFG_INV_BOX_Z: r_inv[2]    <= i_cfg_data;
                CFG_GRID_DIMS: r_dims      <= i_cfg_data[DIMS_W-1:0];
                CFG_CONC_SCL:  r_scale     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign n_eff[0] = eff_count(r_dims[CNT_W-1:0], MAX_BOXES_X);
    assign n_eff[1] = eff_count(r_dims[2*CNT_W-1:CNT_W], MAX_BOXES_Y);
    assign n_eff[2] = eff_count(r_dims[3*CNT_W-1:2*CNT_W], MAX_BOXES_Z);

    assign sel_ok = ({1'b0, r_sel[0]} < n_eff[0]) && ({1'b0, r_sel[1]} < n_eff[1]) &&
                    ({1'b0, r_sel[2]} < n_eff[2]);

    // Shared 32x32 multiplier: axis offset times reciprocal, or count half times scale.
    assign ax      = i_cmd.msel[1:0];
    assign cnt_ext = PROD_W'(r_cnt);

    always_comb begin
        case (i_cmd.msel)
            MSEL_CLO: begin
                mul_a = cnt_ext[MUL_W-1:0];
                mul_b = r_scale;
            end
            MSEL_CHI: begin
                mul_a = cnt_ext[PROD_W-1:MUL_W];
                mul_b = r_scale;
            end
            default: begin
                mul_a = r_mag[ax];
                mul_b = r_inv[ax];
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Floor of the scaled offset; a negative offset only survives when the product is zero or the axis is flat.
    assign idx_hi  = r_prod[PROD_W-1:FRAC_SH];
    assign ax_neg  = r_neg[ax];
    assign ax_flat = r_dims[FLAT_LSB + ax];
    assign e_valid = ax_flat || !ax_neg || (r_prod == '0);
    assign e       = (ax_flat || ax_neg) ? '0 : idx_hi;
    assign axis_ok = e_valid && ((CMP_W'(e) + CMP_W'(1)) < CMP_W'(n_eff[ax]));

    // Count times scale, assembled from the two partial products, saturating.
    assign conc_mid = {1'b0, r_prod[MUL_W-1:0]} + {1'b0, r_p0[PROD_W-1:MUL_W]};
    assign conc_sat = (r_prod[PROD_W-1:MUL_W] != '0) || conc_mid[MUL_W];

    assign n_addr = (r_kind == KIND_READ) ?
                    box_addr(IDX_W'(r_sel[0]), IDX_W'(r_sel[1]), IDX_W'(r_sel[2])) :
                    box_addr(r_idx[0], r_idx[1], r_idx[2]);

    assign upd_data = (r_kind == KIND_READ) ? '0 :
                      ((rd_data == COUNT_MAX) ? rd_data : rd_data + COUNT_BITS'(1));
    assign wr_en    = i_cmd.clr_wr || i_cmd.upd_wr;
    assign wr_addr  = i_cmd.clr_wr ? r_clr_addr : r_addr;
    assign wr_data  = i_cmd.clr_wr ? '0 : upd_data;

    pbh_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (n_addr),
        .o_rd_data (rd_data)
    );

    // Clearing sweep address.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_wr) begin
            r_clr_addr <= r_clr_addr + ADDR_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind   <= i_kind;
            r_go     <= i_active && i_released;
            r_pos[0] <= i_x_pos;
            r_pos[1] <= i_y_pos;
            r_pos[2] <= i_z_pos;
            r_sel[0] <= i_sel_x;
            r_sel[1] <= i_sel_y;
            r_sel[2] <= i_sel_z;
            r_all_ok <= 1'b1;
            r_hit    <= 1'b0;
            r_conc   <= '0;
        end
        if (i_cmd.sub_en) begin
            for (int k = 0; k < 3; k++) begin
                logic signed [POS_W:0] d;
                d        = (POS_W+1)'(r_pos[k]) - (POS_W+1)'(r_origin[k]);
                r_neg[k] <= d[POS_W];
                r_mag[k] <= d[POS_W] ? MUL_W'(-d) : MUL_W'(d);
            end
        end
        if (i_cmd.mul_en) begin
            r_prod <= mul_p;
            if (i_cmd.msel == MSEL_CHI) begin
                r_p0 <= r_prod;
            end
        end
        if (i_cmd.chk_en) begin
            r_idx[ax] <= IDX_W'(e);
            r_all_ok  <= r_all_ok && axis_ok;
        end
        if (i_cmd.rd_en) begin
            r_addr <= n_addr;
        end
        if (i_cmd.upd_wr) begin
            r_cnt <= rd_data;
            r_hit <= 1'b1;
        end
        if (i_cmd.sum_en) begin
            r_conc <= conc_sat ? '1 : {conc_mid[MUL_W-1:0], r_p0[MUL_W-1:0]};
        end
        if (i_cmd.out_load) begin
            r_o_hit  <= r_hit;
            r_o_conc <= r_conc;
            for (int k = 0; k < 3; k++) begin
                if (r_kind == KIND_READ) begin
                    r_o_box[k] <= r_sel[k];
                end else begin
                    r_o_box[k] <= r_hit ? BOX_W'(r_idx[k]) : '0;
                end
            end
        end
    end

    assign o_sts.kind     = r_kind;
    assign o_sts.go       = r_go;
    assign o_sts.sel_ok   = sel_ok;
    assign o_sts.all_ok   = r_all_ok && axis_ok;
    assign o_sts.clr_last = (r_clr_addr == ADDR_W'(DEPTH - 1));

    assign o_in_range      = r_o_hit;
    assign o_box_x         = r_o_box[0];
    assign o_box_y         = r_o_box[1];
    assign o_box_z         = r_o_box[2];
    assign o_concentration = r_o_conc;

    a_write_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.upd_wr |-> $past(i_cmd.rd_en))
        else $error("counter update without a preceding read");

    a_bin_no_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.upd_wr && r_kind == KIND_BIN |-> upd_data != '0)
        else $error("box counter wrapped to zero");

    a_bin_no_conc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load && r_kind == KIND_BIN |-> r_conc == '0)
        else $error("particle item carries a concentration");

endmodule

// ===== design/particle_box_histogram_top.sv =====
// Top level of the particle box histogram: bins particles into 3D count boxes.
// An inactive or unreleased particle, or a read outside the grid, goes from the offset subtraction
// straight to its result; a particle outside the grid ends after its range checks; a counted one
// or a read-and-clear goes on through the counter store. Its result becomes valid in the same
// cycle that the next item can be taken. The shared 32x32 multiplier (once per axis, twice per
// concentration) and the store's read-modify-write set each item's length. Reset clears the store.
module particle_box_histogram_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Input items.
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic                                 i_kind,
    input  logic signed [pbh_pkg::POS_W-1:0]     i_x_pos,
    input  logic signed [pbh_pkg::POS_W-1:0]     i_y_pos,
    input  logic signed [pbh_pkg::POS_W-1:0]     i_z_pos,
    input  logic                                 i_active,
    input  logic                                 i_released,
    input  logic [pbh_pkg::SEL_W-1:0]            i_sel_x,
    input  logic [pbh_pkg::SEL_W-1:0]            i_sel_y,
    input  logic [pbh_pkg::SEL_W-1:0]            i_sel_z,
    // Result items.
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic                                 o_in_range,
    output logic [pbh_pkg::BOX_W-1:0]            o_box_x,
    output logic [pbh_pkg::BOX_W-1:0]            o_box_y,
    output logic [pbh_pkg::BOX_W-1:0]            o_box_z,
    output logic [pbh_pkg::CONC_W-1:0]           o_concentration,
    // Configuration writes.
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [pbh_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [pbh_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import pbh_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    // Configuration registers are plain flops and can take a write in any cycle.
    assign o_cfg_ready = 1'b1;

    // The controller walks one item at a time through its steps: offset subtraction,
    // one multiply and range check per axis, a counter read, the counter write, and for
    // read-and-clear items two partial products and a saturating sum. The finished result
    // goes into an output register, so a new item is accepted while it waits to be taken.
    pbh_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // The datapath holds the configuration, the item, the index arithmetic, the counter
    // store and the result register.
    pbh_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_cfg_we        (i_cfg_valid && o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_kind          (i_kind),
        .i_x_pos         (i_x_pos),
        .i_y_pos         (i_y_pos),
        .i_z_pos         (i_z_pos),
        .i_active        (i_active),
        .i_released      (i_released),
        .i_sel_x         (i_sel_x),
        .i_sel_y         (i_sel_y),
        .i_sel_z         (i_sel_z),
        .o_in_range      (o_in_range),
        .o_box_x         (o_box_x),
        .o_box_y         (o_box_y),
        .o_box_z         (o_box_z),
        .o_concentration (o_concentration)
    );

endmodule

// ===== tb/sv/particle_box_histogram_top_test.sv =====
// Self-checking testbench for the particle box histogram top level.
`timescale 1ns / 1ps

module particle_box_histogram_top_test;
    import pbh_pkg::*;

    // Each side may idle for a random gap before each item. About 700 items,
    // even at the slowest walk and longest gaps, the clearing pass and the
    // register writes stay far below this limit.
    localparam int LIMIT_CYCLES    = 300000;
    localparam int PHASES          = 10;
    localparam int ITEMS_PER_PHASE = 65;
    localparam int MAX_GAP         = 11;
    localparam int RECENT_DEPTH    = 24;
    localparam logic [CFG_IDX_W-1:0] FIRST_SPARE_IDX = CFG_CONC_SCL + 1'b1;

    typedef struct packed {
        logic                    kind;
        logic signed [POS_W-1:0] x_pos;
        logic signed [POS_W-1:0] y_pos;
        logic signed [POS_W-1:0] z_pos;
        logic                    active;
        logic                    released;
        logic [SEL_W-1:0]        sel_x;
        logic [SEL_W-1:0]        sel_y;
        logic [SEL_W-1:0]        sel_z;
    } t_particle_item;

    typedef struct packed {
        logic              in_range;
        logic [BOX_W-1:0]  box_x;
        logic [BOX_W-1:0]  box_y;
        logic [BOX_W-1:0]  box_z;
        logic [CONC_W-1:0] concentration;
    } t_box_result;

    // One line of the directed stimulus. When typed is set, res holds the
    // result worked out by hand and replaces the predicted one.
    typedef struct packed {
        t_particle_item item;
        logic           typed;
        t_box_result    res;
    } t_directed_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_stall;
    logic                   i_kind = KIND_BIN;
    logic signed [POS_W-1:0] i_x_pos = '0;
    logic signed [POS_W-1:0] i_y_pos = '0;
    logic signed [POS_W-1:0] i_z_pos = '0;
    logic                   i_active = 1'b0;
    logic                   i_released = 1'b0;
    logic [SEL_W-1:0]       i_sel_x = '0;
    logic [SEL_W-1:0]       i_sel_y = '0;
    logic [SEL_W-1:0]       i_sel_z = '0;
    logic                   o_out_valid;
    logic                   i_out_stall = 1'b0;
    logic                   o_in_range;
    logic [BOX_W-1:0]       o_box_x;
    logic [BOX_W-1:0]       o_box_y;
    logic [BOX_W-1:0]       o_box_z;
    logic [CONC_W-1:0]      o_concentration;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    // Our own copy of the block's registers and counter store.
    logic signed [POS_W-1:0] org_q [3];
    logic [MUL_W-1:0]        inv_q [3];
    logic [DIMS_W-1:0]       dims_q;
    logic [MUL_W-1:0]        scale_q;
    logic [COUNT_BITS-1:0]   box_count [DEPTH];

    // Results still owed by the block, oldest first, and boxes counted lately,
    // so that reads often land on boxes that hold something.
    t_box_result             pending_results [$];
    logic [3*SEL_W-1:0]      recent_hits [$];

    // Box size in Q16.16 of the current setting, 0 where the reciprocals are
    // extremes that have no useful box size.
    int                      box_step = 0;
    int                      tx_calm = 0;
    int                      rx_calm = 0;
    int                      n_fail = 0;
    int                      cycle_cnt = 0;

    particle_box_histogram_top DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_kind          (i_kind),
        .i_x_pos         (i_x_pos),
        .i_y_pos         (i_y_pos),
        .i_z_pos         (i_z_pos),
        .i_active        (i_active),
        .i_released      (i_released),
        .i_sel_x         (i_sel_x),
        .i_sel_y         (i_sel_y),
        .i_sel_z         (i_sel_z),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_in_range      (o_in_range),
        .o_box_x         (o_box_x),
        .o_box_y         (o_box_y),
        .o_box_z         (o_box_z),
        .o_concentration (o_concentration),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == LIMIT_CYCLES) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Box count of one axis, with a field above the grid size taken as the grid size.
    function automatic int axis_count(input int k);
        int f;
        int m;
        f = int'(dims_q[k*CNT_W +: CNT_W]);
        m = (k == 0) ? MAX_BOXES_X : (k == 1) ? MAX_BOXES_Y : MAX_BOXES_Z;
        return (f > m) ? m : f;
    endfunction

    // floor((pos - org) * inv / 2^40), worked out exactly on 33 and 65 bits.
    // Every negative result collapses to -1, since it is outside either way,
    // but a negative offset with a zero product still lands in box 0.
    function automatic longint axis_index(input logic [POS_W-1:0] pos,
                                          input logic [POS_W-1:0] org,
                                          input logic [MUL_W-1:0] inv);
        logic [POS_W:0]  diff;
        logic [POS_W:0]  mag;
        logic [64:0]     prod;
        diff = {pos[POS_W-1], pos} - {org[POS_W-1], org};
        mag  = diff[POS_W] ? (~diff + 1'b1) : diff;
        prod = 65'(mag) * 65'(inv);
        if (diff[POS_W])
            return (prod == '0) ? 0 : -1;
        return longint'(prod >> FRAC_SH);
    endfunction

    // Applies one item to our copy of the store and returns the result it owes.
    function automatic t_box_result histogram_step(input t_particle_item it);
        t_box_result           r;
        int                    n [3];
        longint                idx [3];
        logic [POS_W-1:0]      pos [3];
        logic [SEL_W-1:0]      sel [3];
        bit                    ok;
        int                    addr;
        r = '0;
        for (int k = 0; k < 3; k++)
            n[k] = axis_count(k);
        if (it.kind == KIND_BIN) begin
            if (it.active && it.released) begin
                pos[0] = it.x_pos;
                pos[1] = it.y_pos;
                pos[2] = it.z_pos;
                ok = 1'b1;
                for (int k = 0; k < 3; k++) begin
                    idx[k] = dims_q[FLAT_LSB + k] ? 0 : axis_index(pos[k], org_q[k], inv_q[k]);
                    // The last box of each axis is never counted.
                    ok &= (idx[k] >= 0) && (idx[k] < n[k] - 1);
                end
                if (ok) begin
                    addr = int'((idx[2] * MAX_BOXES_Y + idx[1]) * MAX_BOXES_X + idx[0]);
                    if (box_count[addr] != COUNT_MAX)
                        box_count[addr] += 1'b1;
                    r.in_range = 1'b1;
                    r.box_x = BOX_W'(idx[0]);
                    r.box_y = BOX_W'(idx[1]);
                    r.box_z = BOX_W'(idx[2]);
                    recent_hits = {recent_hits, {r.box_z, r.box_y, r.box_x}};
                    if (recent_hits.size() > RECENT_DEPTH)
                        void'(recent_hits.pop_front());
                end
            end
        end else begin
            sel[0] = it.sel_x;
            sel[1] = it.sel_y;
            sel[2] = it.sel_z;
            // A read outside the grid echoes its box and clears nothing.
            r.box_x = sel[0];
            r.box_y = sel[1];
            r.box_z = sel[2];
            if (int'(sel[0]) < n[0] && int'(sel[1]) < n[1] && int'(sel[2]) < n[2]) begin
                addr = (int'(sel[2]) * MAX_BOXES_Y + int'(sel[1])) * MAX_BOXES_X + int'(sel[0]);
                r.concentration = CONC_W'(box_count[addr]) * CONC_W'(scale_q);
                r.in_range = 1'b1;
                box_count[addr] = '0;
            end
        end
        return r;
    endfunction

    function automatic t_directed_row bin_row(input logic [POS_W-1:0] x, y, z,
                                              input logic act, rel, typed, hit,
                                              input logic [BOX_W-1:0] bx, by, bz);
        t_directed_row r;
        r = '0;
        r.item.kind     = KIND_BIN;
        r.item.x_pos    = x;
        r.item.y_pos    = y;
        r.item.z_pos    = z;
        r.item.active   = act;
        r.item.released = rel;
        // Box selectors mean nothing to a particle item.
        r.item.sel_x    = '1;
        r.item.sel_y    = '1;
        r.item.sel_z    = '1;
        r.typed         = typed;
        r.res.in_range  = hit;
        r.res.box_x     = bx;
        r.res.box_y     = by;
        r.res.box_z     = bz;
        return r;
    endfunction

    // Reads in the directed part run under the reset grid, where every box is valid.
    function automatic t_directed_row read_row(input logic [SEL_W-1:0] sx, sy, sz,
                                               input logic typed,
                                               input logic [CONC_W-1:0] conc);
        t_directed_row r;
        r = '0;
        r.item.kind          = KIND_READ;
        r.item.x_pos         = '1;
        r.item.y_pos         = '1;
        r.item.z_pos         = '1;
        r.item.active        = 1'b1;
        r.item.released      = 1'b1;
        r.item.sel_x         = sx;
        r.item.sel_y         = sy;
        r.item.sel_z         = sz;
        r.typed              = typed;
        r.res.in_range       = 1'b1;
        r.res.box_x          = sx;
        r.res.box_y          = sy;
        r.res.box_z          = sz;
        r.res.concentration  = conc;
        return r;
    endfunction

    // Idle cycles before the next item: mostly a random gap of up to MAX_GAP,
    // now and then a calm stretch of back-to-back items.
    task automatic draw_gap(inout int calm, output int gap);
        if (calm > 0) begin
            calm--;
            gap = 0;
        end else begin
            gap = $urandom_range(0, MAX_GAP);
            if ($urandom_range(0, 15) == 0)
                calm = $urandom_range(8, 30);
        end
    endtask

    // One register write; the predictor takes the value once the block has.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        case (idx)
            CFG_ORIGIN_X:  org_q[0] = data;
            CFG_ORIGIN_Y:  org_q[1] = data;
            CFG_ORIGIN_Z:  org_q[2] = data;
            CFG_INV_BOX_X: inv_q[0] = data;
            CFG_INV_BOX_Y: inv_q[1] = data;
            CFG_INV_BOX_Z: inv_q[2] = data;
            CFG_GRID_DIMS: dims_q   = data[DIMS_W-1:0];
            CFG_CONC_SCL:  scale_q  = data;
            default: ;
        endcase
    endtask

    // Offers one item and returns at the edge that accepts it. The payload
    // only changes once the previous item has been taken.
    task automatic send_item(input t_particle_item it);
        int gap;
        draw_gap(tx_calm, gap);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind     <= it.kind;
        i_x_pos    <= it.x_pos;
        i_y_pos    <= it.y_pos;
        i_z_pos    <= it.z_pos;
        i_active   <= it.active;
        i_released <= it.released;
        i_sel_x    <= it.sel_x;
        i_sel_y    <= it.sel_y;
        i_sel_z    <= it.sel_z;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
    endtask

    // Random item under the current setting. Most positions fall in or just
    // past the grid so that boxes fill up; the rest sit just below the origin
    // or anywhere at all. Reads favor boxes that were counted lately.
    task automatic make_item(output t_particle_item it);
        logic [POS_W-1:0] p [3];
        int               n;
        int               pick;
        for (int k = 0; k < 3; k++) begin
            n    = axis_count(k);
            pick = $urandom_range(0, 9);
            if (box_step == 0 || pick == 9)
                p[k] = $urandom;
            else if (pick < 8)
                p[k] = org_q[k] + $urandom_range(0, (n + 1) * box_step);
            else
                p[k] = org_q[k] - $urandom_range(1, 1 << 16);
        end
        it.kind  = ($urandom_range(0, 9) < 3) ? KIND_READ : KIND_BIN;
        it.x_pos = p[0];
        it.y_pos = p[1];
        it.z_pos = p[2];
        {it.active, it.released} = ($urandom_range(0, 9) < 8) ? 2'b11 : 2'($urandom_range(0, 3));
        pick = $urandom_range(0, 9);
        if (pick < 5 && recent_hits.size() > 0) begin
            {it.sel_z, it.sel_y, it.sel_x} = recent_hits[$urandom_range(0, recent_hits.size() - 1)];
        end else if (pick < 8) begin
            it.sel_x = SEL_W'($urandom_range(0, (axis_count(0) > 0) ? axis_count(0) - 1 : 0));
            it.sel_y = SEL_W'($urandom_range(0, (axis_count(1) > 0) ? axis_count(1) - 1 : 0));
            it.sel_z = SEL_W'($urandom_range(0, (axis_count(2) > 0) ? axis_count(2) - 1 : 0));
        end else begin
            {it.sel_z, it.sel_y, it.sel_x} = (3*SEL_W)'($urandom);
        end
    endtask

    // Result side: stalls a random number of cycles before each item, then
    // compares the item taken with the oldest result still owed.
    initial begin : result_sink
        t_box_result got;
        t_box_result want;
        int          gap;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            draw_gap(rx_calm, gap);
            if (gap > 0) begin
                i_out_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
            got = {o_in_range, o_box_x, o_box_y, o_box_z, o_concentration};
            if (pending_results.size() == 0) begin
                $display("%0t: result with none owed: in_range=%0d box=(%0d,%0d,%0d) conc=%h",
                         $time, got.in_range, got.box_x, got.box_y, got.box_z,
                         got.concentration);
                n_fail++;
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    $display({"%0t: result mismatch: expected in_range=%0d box=(%0d,%0d,%0d) ",
                              "conc=%h, actual in_range=%0d box=(%0d,%0d,%0d) conc=%h"},
                             $time, want.in_range, want.box_x, want.box_y, want.box_z,
                             want.concentration, got.in_range, got.box_x, got.box_y,
                             got.box_z, got.concentration);
                    n_fail++;
                end
            end
        end
    end

    // Stimulus: the directed rows under the reset setting, then random
    // phases, each with its own register setting written while the block idles.
    initial begin : stimulus
        t_directed_row            rows [$];
        t_particle_item           it;
        t_box_result              want;
        logic [CFG_DATA_W-1:0]    org_w [3];
        logic [CFG_DATA_W-1:0]    inv_w [3];
        logic [CFG_DATA_W-1:0]    scl_w;
        logic [DIMS_W-1:0]        dims_w;
        for (int k = 0; k < 3; k++) begin
            org_q[k] = '0;
            inv_q[k] = RST_INV;
        end
        dims_q  = RST_DIMS;
        scale_q = RST_SCALE;
        for (int a = 0; a < DEPTH; a++)
            box_count[a] = '0;
        // Reset setting: unit boxes, so each index is the integer part of the
        // Q16.16 position and 16 boxes per axis, of which 0 to 14 count.
        box_step = 1 << 16;

        // The store starts cleared, and the far corner is still a valid read.
        rows = {rows, read_row(4'd0, 4'd0, 4'd0, 1'b1, '0)};
        rows = {rows, read_row(4'd15, 4'd15, 4'd15, 1'b1, '0)};
        // Two hits on one box, then a read returns the count scaled by 1.0
        // and a second read finds it cleared.
        rows = {rows, bin_row(32'h0001_8000, 32'h0002_4000, 32'h0003_0000,
                              1'b1, 1'b1, 1'b1, 1'b1, 4'd1, 4'd2, 4'd3)};
        rows = {rows, bin_row(32'h0001_8000, 32'h0002_4000, 32'h0003_0000,
                              1'b1, 1'b1, 1'b1, 1'b1, 4'd1, 4'd2, 4'd3)};
        rows = {rows, read_row(4'd1, 4'd2, 4'd3, 1'b1, 64'h2_0000)};
        rows = {rows, read_row(4'd1, 4'd2, 4'd3, 1'b1, '0)};
        // Inactive or not yet released particles are never counted.
        rows = {rows, bin_row(32'h0001_8000, 32'h0002_4000, 32'h0003_0000,
                              1'b0, 1'b1, 1'b1, 1'b0, 4'd0, 4'd0, 4'd0)};
        rows = {rows, bin_row(32'h0001_8000, 32'h0002_4000, 32'h0003_0000,
                              1'b1, 1'b0, 1'b1, 1'b0, 4'd0, 4'd0, 4'd0)};
        rows = {rows, bin_row(32'h0001_8000, 32'h0002_4000, 32'h0003_0000,
                              1'b0, 1'b0, 1'b1, 1'b0, 4'd0, 4'd0, 4'd0)};
        // Box 14 is the last one counted; box 15 is dropped.
        rows = {rows, bin_row(32'h000E_FFFF, 32'h0000_0000, 32'h0000_8000,
                              1'b1, 1'b1, 1'b1, 1'b1, 4'd14, 4'd0, 4'd0)};
        rows = {rows, bin_row(32'h000F_0000, 32'h0000_0000, 32'h0000_0000,
                              1'b1, 1'b1, 1'b1, 1'b0, 4'd0, 4'd0, 4'd0)};
        // One step below the origin, and the extremes of the position range.
        rows = {rows, bin_row(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000,
                              1'b1, 1'b1, 1'b1, 1'b0, 4'd0, 4'd0, 4'd0)};
        rows = {rows, bin_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                              1'b1, 1'b1, 1'b1, 1'b0, 4'd0, 4'd0, 4'd0)};
        rows = {rows, bin_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                              1'b1, 1'b1, 1'b1, 1'b0, 4'd0, 4'd0, 4'd0)};
        rows = {rows, bin_row(32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
                              1'b1, 1'b1, 1'b1, 1'b1, 4'd0, 4'd0, 4'd0)};
        rows = {rows, bin_row(32'h0000_0000, 32'h000E_0000, 32'h000E_FFFF,
                              1'b1, 1'b1, 1'b1, 1'b1, 4'd0, 4'd14, 4'd14)};
        rows = {rows, bin_row(32'h0000_0000, 32'h0000_0000, 32'h000F_0000,
                              1'b1, 1'b1, 1'b1, 1'b0, 4'd0, 4'd0, 4'd0)};
        rows = {rows, read_row(4'd14, 4'd0, 4'd0, 1'b1, 64'h1_0000)};
        rows = {rows, read_row(4'd0, 4'd0, 4'd0, 1'b1, 64'h1_0000)};
        rows = {rows, read_row(4'd0, 4'd14, 4'd14, 1'b1, 64'h1_0000)};
        // Ordinary fractional positions, left to the predictor.
        rows = {rows, bin_row(32'h0007_3A51, 32'h0002_C00F, 32'h000B_1234,
                              1'b1, 1'b1, 1'b0, 1'b0, 4'd0, 4'd0, 4'd0)};
        rows = {rows, read_row(4'd7, 4'd2, 4'd11, 1'b0, '0)};

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The block stalls through its clearing pass; the handshake waits it out.
        foreach (rows[i]) begin
            send_item(rows[i].item);
            want = histogram_step(rows[i].item);
            if (rows[i].typed)
                want = rows[i].res;
            pending_results = {pending_results, want};
        end
        i_in_valid <= 1'b0;

        for (int ph = 0; ph < PHASES; ph++) begin
            // Registers change only once every owed result is back.
            while (pending_results.size() != 0)
                @(posedge i_clk);

            box_step = $urandom_range(1 << 12, 1 << 20);
            for (int k = 0; k < 3; k++) begin
                org_w[k] = 32'($urandom_range(0, 1 << 30)) - 32'h2000_0000;
                inv_w[k] = 32'((64'd1 << FRAC_SH) / box_step);
            end
            dims_w = {3'b000, 5'($urandom_range(2, 17)), 5'($urandom_range(2, 17)),
                      5'($urandom_range(2, 17))};
            scl_w  = $urandom;
            case (ph)
                0: begin
                    // Lowest origins and zero reciprocals: every particle lands
                    // in box 0, and reads scale by the largest factor.
                    org_w  = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
                    inv_w  = '{32'h0, 32'h0, 32'h0};
                    dims_w = {3'b000, 5'd16, 5'd16, 5'd16};
                    scl_w  = '1;
                    box_step = 0;
                end
                1: begin
                    // Highest origins and reciprocals, all axes flat, counts
                    // above the grid size, zero scale.
                    org_w  = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
                    inv_w  = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
                    dims_w = '1;
                    scl_w  = '0;
                    box_step = 0;
                end
                // No boxes at all: nothing counts and every read is outside.
                2: dims_w = '0;
                // One box per axis: no particle counts, only box 0 reads.
                3: dims_w = {3'b000, 5'd1, 5'd1, 5'd1};
                4: begin
                    // Tiny boxes with reciprocals near the top of their range,
                    // and some axes flat.
                    box_step = $urandom_range(257, 4096);
                    for (int k = 0; k < 3; k++)
                        inv_w[k] = 32'((64'd1 << FRAC_SH) / box_step);
                    dims_w[FLAT_LSB +: 3] = 3'($urandom_range(1, 7));
                end
                5: dims_w = {3'b000, 5'd31, 5'd31, 5'd31};
                // Two boxes per axis: only box 0 counts.
                6: dims_w = {3'b000, 5'd2, 5'd2, 5'd2};
                default: ;
            endcase

            // An index past the register list must be ignored.
            cfg_write(CFG_IDX_W'($urandom_range(FIRST_SPARE_IDX, (1 << CFG_IDX_W) - 1)),
                      $urandom);
            cfg_write(CFG_ORIGIN_X,  org_w[0]);
            cfg_write(CFG_ORIGIN_Y,  org_w[1]);
            cfg_write(CFG_ORIGIN_Z,  org_w[2]);
            cfg_write(CFG_INV_BOX_X, inv_w[0]);
            cfg_write(CFG_INV_BOX_Y, inv_w[1]);
            cfg_write(CFG_INV_BOX_Z, inv_w[2]);
            cfg_write(CFG_GRID_DIMS, CFG_DATA_W'(dims_w));
            cfg_write(CFG_CONC_SCL,  scl_w);
            i_cfg_valid <= 1'b0;

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                make_item(it);
                send_item(it);
                want = histogram_step(it);
                pending_results = {pending_results, want};
            end
            i_in_valid <= 1'b0;
        end

        // Drain, then give a stray extra result time to show up.
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (n_fail == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
